// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion helpers, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/urlpe_pkg.sv =====
// ----------------------------------------------------------------------------
// urlpe_pkg
// shared types, constants and helpers of the url percent encoder
// ----------------------------------------------------------------------------
`default_nettype none

package urlpe_pkg;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_DASH    = 8'h2D;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UP_A    = 8'h41;
  localparam logic [7:0] CH_UP_F    = 8'h46;
  localparam logic [7:0] CH_UP_Z    = 8'h5A;
  localparam logic [7:0] CH_LO_A    = 8'h61;
  localparam logic [7:0] CH_LO_Z    = 8'h7A;
  localparam logic [7:0] HEX_NUM_OFS = 8'd48;
  localparam logic [7:0] HEX_ALPHA_OFS = 8'd55;

  // classified item between front and back
  typedef struct packed {
    logic [7:0] data;
    logic       esc;
  } urlpe_entry_t;

  // back serializer phase
  typedef enum logic [1:0] {
    PH_HEAD,
    PH_HI,
    PH_LO
  } urlpe_phase_t;

  function automatic logic passes_through(input logic [7:0] c);
    logic digit, upper, lower, punct;
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    upper = (c >= CH_UP_A) && (c <= CH_UP_Z);
    lower = (c >= CH_LO_A) && (c <= CH_LO_Z);
    punct = (c == CH_DOT) || (c == CH_SLASH) || (c == CH_DASH) || (c == CH_COLON);
    return digit || upper || lower || punct;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'd0, nib};
    return (nib > 4'd9) ? (wide + HEX_ALPHA_OFS) : (wide + HEX_NUM_OFS);
  endfunction

endpackage

`default_nettype wire

// ===== sv/urlpe_front.sv =====
// ----------------------------------------------------------------------------
// urlpe_front
// accepts raw bytes, classifies them and hands them to the queue
// ----------------------------------------------------------------------------
`default_nettype none

module urlpe_front (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [7:0]             in_byte,
  output logic                        push_valid,
  input  wire logic                   push_ready,
  output urlpe_pkg::urlpe_entry_t     push_entry
);
  import urlpe_pkg::*;

  logic         valid_r, valid_nxt;
  urlpe_entry_t entry_r, entry_nxt;
  logic         take;

  assign in_ready   = !valid_r || push_ready;
  assign take       = in_valid && in_ready;
  assign push_valid = valid_r;
  assign push_entry = entry_r;

  always_comb begin
    valid_nxt = valid_r;
    entry_nxt = entry_r;
    if (take) begin
      valid_nxt      = 1'b1;
      entry_nxt.data = in_byte;
      entry_nxt.esc  = !passes_through(in_byte);
    end else if (push_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

`default_nettype wire

// ===== sv/urlpe_queue.sv =====
// ----------------------------------------------------------------------------
// urlpe_queue
// short fifo of classified bytes between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module urlpe_queue (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push_valid,
  output logic                            push_ready,
  input  wire urlpe_pkg::urlpe_entry_t    push_entry,
  output logic                            pop_valid,
  input  wire logic                       pop_ready,
  output urlpe_pkg::urlpe_entry_t         pop_entry,
  output logic [urlpe_pkg::QCNT_W-1:0]    level
);
  import urlpe_pkg::*;

  urlpe_entry_t      mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = (count_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_entry  = mem_r[rd_ptr_r];
  assign level      = count_r;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_nxt = do_push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

// ===== sv/urlpe_back.sv =====
// ----------------------------------------------------------------------------
// urlpe_back
// serializes each queued byte into one or three output characters
// ----------------------------------------------------------------------------
`default_nettype none

module urlpe_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       pop_valid,
  output logic                            pop_ready,
  input  wire urlpe_pkg::urlpe_entry_t    pop_entry,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [7:0]                      out_byte,
  output logic                            out_run_last
);
  import urlpe_pkg::*;

  urlpe_phase_t phase_r, phase_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [7:0]   out_byte_r, out_byte_nxt;
  logic         out_last_r, out_last_nxt;
  logic [7:0]   cur_r, cur_nxt;
  logic         slot_free;

  assign slot_free    = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign out_run_last = out_last_r;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (slot_free) begin
      unique case (phase_r)
        PH_HEAD: if (pop_valid && pop_entry.esc) phase_nxt = PH_HI;
        PH_HI:   phase_nxt = PH_LO;
        PH_LO:   phase_nxt = PH_HEAD;
        default: phase_nxt = PH_HEAD;
      endcase
    end
  end

  // output register and pop
  always_comb begin
    pop_ready     = 1'b0;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    cur_nxt       = cur_r;
    if (slot_free) begin
      unique case (phase_r)
        PH_HEAD: begin
          pop_ready     = 1'b1;
          out_valid_nxt = pop_valid;
          cur_nxt       = pop_entry.data;
          out_byte_nxt  = pop_entry.esc ? CH_PERCENT : pop_entry.data;
          out_last_nxt  = !pop_entry.esc;
        end
        PH_HI: begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = hex_digit(cur_r[7:4]);
          out_last_nxt  = 1'b0;
        end
        PH_LO: begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = hex_digit(cur_r[3:0]);
          out_last_nxt  = 1'b1;
        end
        default: begin
          out_valid_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEAD;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    cur_r      <= cur_nxt;
  end

endmodule

`default_nettype wire

// ===== sv/url_percent_encoder.sv =====
// ----------------------------------------------------------------------------
// url_percent_encoder
// url percent encoding of a byte stream, one raw byte in per beat
// ----------------------------------------------------------------------------
// in_valid/in_ready carry one raw byte per beat on in_byte. out_valid/out_ready
// carry one encoded character per beat on out_byte; out_run_last marks the
// final character produced by an input byte.
// digits, letters and . / - : come out as themselves (one beat); any other
// byte comes out as '%' and two upper-case hex digits (three beats).
// an accepted byte passes through the front register, then a queue entry, then
// the output register; a full queue or a held out_ready can stall it between.
// throughput: one output beat per cycle while out_ready stays high, set by the
// output serializer; so one input per cycle for pass-through bytes, while an
// escaped byte holds the serializer for its three characters. the front keeps
// accepting while the queue has room.
// reset (synchronous, rst_n low) empties the front stage, the queue and the
// output register and returns the serializer phase to its head.
// when the receiver holds out_ready low the output beat holds, the queue
// fills, and in_ready drops once front and queue are full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module url_percent_encoder (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_run_last
);
  import urlpe_pkg::*;

  logic              push_valid, push_ready;
  urlpe_entry_t      push_entry;
  logic              pop_valid, pop_ready;
  urlpe_entry_t      pop_entry;
  logic [QCNT_W-1:0] q_level;
  logic              esc_char_ok;

  urlpe_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  urlpe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry),
    .level      (q_level)
  );

  urlpe_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_entry    (pop_entry),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_run_last (out_run_last)
  );

  assign esc_char_ok = (out_byte == CH_PERCENT) ||
                       ((out_byte >= CH_ZERO) && (out_byte <= CH_NINE)) ||
                       ((out_byte >= CH_UP_A) && (out_byte <= CH_UP_F));

  // queue never overfills
  `ASSERT_IMPLIES(a_q_level, clk, rst_n, 1'b1, q_level <= QCNT_W'(QDEPTH))
  // an escape sequence continues without a gap
  `ASSERT_NEXT(a_esc_cont, clk, rst_n, out_valid && out_ready && !out_run_last, out_valid)
  // inside an escape sequence only '%' or hex digits appear
  `ASSERT_IMPLIES(a_esc_chars, clk, rst_n, out_valid && !out_run_last, esc_char_ok)

endmodule

`default_nettype wire

// ===== tb/sv/url_percent_encoder_tb.sv =====
// ----------------------------------------------------------------------------
// url_percent_encoder_tb
// self-checking bench for the url percent encoder: raw bytes go in, a local
// encoder predicts each character, and every output beat is compared with it
// ----------------------------------------------------------------------------
module url_percent_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import urlpe_pkg::*;

  localparam int IDLE_LIMIT = 2000;

  typedef struct {
    logic [7:0] chr;
    logic       last;
  } enc_char_t;

  typedef enum int {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PATTERN,
    RX_BURSTY
  } rx_mode_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic       out_run_last;

  enc_char_t  pending_chars[$];
  int         errors;
  int         bytes_sent;
  int         escaped_sent;
  int         chars_checked;

  // sender burst control
  bit         gaps_on;
  int         burst_left;

  // receiver stall pattern
  rx_mode_t    stall_mode;
  int          mode_cycles;
  int          stall_run;
  logic [7:0]  ready_mask;
  int unsigned mask_pos;
  logic        rx_next;

  url_percent_encoder uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_run_last (out_run_last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic is_literal_char(input logic [7:0] c);
    return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_UP_A && c <= CH_UP_Z) ||
           (c >= CH_LO_A && c <= CH_LO_Z) || c == CH_DOT || c == CH_SLASH ||
           c == CH_DASH || c == CH_COLON;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    return (nib > 4'd9) ? (8'(nib) + HEX_ALPHA_OFS) : (8'(nib) + HEX_NUM_OFS);
  endfunction

  // append one expected character at the tail of the queue
  function automatic void expect_char(input logic [7:0] chr, input logic last);
    enc_char_t item;
    item.chr  = chr;
    item.last = last;
    pending_chars.insert(pending_chars.size(), item);
  endfunction

  // expected characters for one raw byte
  task automatic push_encoding(input logic [7:0] b);
    if (is_literal_char(b)) begin
      expect_char(b, 1'b1);
    end else begin
      expect_char(CH_PERCENT, 1'b0);
      expect_char(hex_char(b[7:4]), 1'b0);
      expect_char(hex_char(b[3:0]), 1'b1);
      escaped_sent++;
    end
  endtask

  function automatic logic [7:0] random_literal();
    int unsigned r;
    r = $urandom_range(0, 65);
    if (r < 10) return CH_ZERO + 8'(r);
    if (r < 36) return CH_LO_A + 8'(r - 10);
    if (r < 62) return CH_UP_A + 8'(r - 36);
    case (r)
      62: return CH_DOT;
      63: return CH_SLASH;
      64: return CH_DASH;
      default: return CH_COLON;
    endcase
  endfunction

  function automatic logic [7:0] random_escaped();
    logic [7:0] b;
    b = 8'($urandom);
    while (is_literal_char(b)) b = 8'($urandom);
    return b;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    push_encoding(b);
    bytes_sent++;
    if (burst_left > 0) burst_left--;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 8);
      @(negedge clk);
      in_valid <= 1'b0;
      in_byte  <= 8'($urandom);
      repeat (gap - 1) @(negedge clk);
      burst_left = $urandom_range(1, 16);
    end
  endtask

  task automatic sender_rest();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    sender_rest();
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  task automatic test_literal_boundaries();
    logic [7:0] edge_bytes [24] = '{
      8'h00, 8'hFF, 8'h20, CH_ZERO, CH_NINE, CH_SLASH, CH_COLON, 8'h3B,
      8'h40, CH_UP_A, CH_UP_Z, 8'h5B, 8'h60, CH_LO_A, CH_LO_Z, 8'h7B,
      CH_DOT, CH_DASH, 8'h2C, CH_PERCENT, 8'h7F, 8'h80, 8'h0A, CH_UP_F
    };
    gaps_on = 1'b1;
    foreach (edge_bytes[i]) send_byte(edge_bytes[i]);
    sender_rest();
  endtask

  task automatic test_random_bytes();
    gaps_on = 1'b1;
    repeat (90) send_byte(8'($urandom));
    sender_rest();
  endtask

  // mostly literal characters with escapes sprinkled in, like real text
  task automatic test_text_like();
    gaps_on = 1'b1;
    repeat (70) begin
      if ($urandom_range(0, 9) < 7) send_byte(random_literal());
      else send_byte(8'($urandom));
    end
    sender_rest();
  endtask

  // back-to-back escapes stress the serializer; a full drain in the middle
  task automatic test_escape_stream();
    gaps_on = 1'b0;
    repeat (25) send_byte(random_escaped());
    wait_drained();
    repeat (20) send_byte(random_escaped());
    sender_rest();
    gaps_on = 1'b1;
  endtask

  // receiver stalls follow a randomly chosen mode, drawn again when its random run length is used up
  always @(negedge clk) begin
    if (mode_cycles == 0) begin
      stall_mode  = rx_mode_t'($urandom_range(0, 3));
      mode_cycles = $urandom_range(20, 60);
      ready_mask  = 8'($urandom);
      if (ready_mask == 8'h00) ready_mask = 8'h01;
    end
    mode_cycles--;
    case (stall_mode)
      RX_ALWAYS: rx_next = 1'b1;
      RX_RANDOM: rx_next = ($urandom_range(0, 3) != 0);
      RX_PATTERN: begin
        rx_next  = ready_mask[mask_pos];
        mask_pos = (mask_pos + 1) % 8;
      end
      default: begin
        if (stall_run > 0) begin
          rx_next = 1'b0;
          stall_run--;
        end else begin
          rx_next = 1'b1;
          if ($urandom_range(0, 9) == 0) stall_run = $urandom_range(3, 12);
        end
      end
    endcase
    out_ready <= rx_next;
  end

  // output beat check against the oldest expected character
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected output beat: out_byte %h out_run_last %b", out_byte,
               out_run_last);
        errors++;
      end else begin
        if (out_byte !== pending_chars[0].chr) begin
          $error("out_byte: expected %h, got %h", pending_chars[0].chr, out_byte);
          errors++;
        end
        if (out_run_last !== pending_chars[0].last) begin
          $error("out_run_last: expected %b, got %b", pending_chars[0].last,
                 out_run_last);
          errors++;
        end
        void'(pending_chars.pop_front());
        chars_checked++;
      end
    end
  end

  // watchdog on cycles with no beat on either side
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("timeout: no beat for %0d cycles, %0d characters still expected",
             IDLE_LIMIT, pending_chars.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_byte       = 8'h00;
    out_ready     = 1'b0;
    errors        = 0;
    bytes_sent    = 0;
    escaped_sent  = 0;
    chars_checked = 0;
    gaps_on       = 1'b1;
    burst_left    = $urandom_range(1, 16);
    stall_mode    = RX_ALWAYS;
    mode_cycles   = 0;
    stall_run     = 0;
    ready_mask    = 8'hFF;
    mask_pos      = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_literal_boundaries();
    test_random_bytes();
    test_text_like();
    test_escape_stream();

    wait_drained();
    repeat (12) @(posedge clk);
    if (pending_chars.size() != 0) begin
      $error("%0d expected characters never arrived", pending_chars.size());
      errors++;
    end

    $display("sent %0d raw bytes (%0d escaped, %0d literal), checked %0d characters",
             bytes_sent, escaped_sent, bytes_sent - escaped_sent, chars_checked);
    $display("covered range edges, sender gaps, receiver stall modes and a full drain");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/urlpe_pkg.sv
sv/urlpe_front.sv
sv/urlpe_queue.sv
sv/urlpe_back.sv
sv/url_percent_encoder.sv
tb/sv/url_percent_encoder_tb.sv
